// ===== rtl/hpcd_pkg.sv =====
// Package with the types and constants shared by the carriage detector modules.
`timescale 1ns / 1ps

package hpcd_pkg;

  localparam int unsigned SampleW = 10;
  localparam int unsigned PosW    = 8;
  localparam int unsigned DirW    = 2;

  localparam int unsigned NEEDLE_WINDOW_DEF = 3;

  localparam logic [SampleW-1:0] LOW_THR_RST  = 10'd0;
  localparam logic [SampleW-1:0] HIGH_THR_RST = 10'd1023;

  typedef enum logic [0:0] {
    CFG_LOW_THR  = 1'b0,
    CFG_HIGH_THR = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_K    = 2'd1,
    KIND_L    = 2'd2,
    KIND_G    = 2'd3
  } kind_e;

  typedef struct packed {
    logic [DirW-1:0]    travel_dir;
    logic [PosW-1:0]    needle_pos;
    logic [SampleW-1:0] sample;
  } item_t;

  typedef struct packed {
    logic            hunting;
    logic [PosW-1:0] carriage_pos;
    kind_e           carriage_kind;
    logic            detected;
  } result_t;

endpackage

// ===== rtl/hall_pole_carriage_detector_unit.sv =====
// Top level of the hall sensor carriage detector with stream ports and config registers.
`timescale 1ns / 1ps

// Usage: each input word on the s_axis channel carries one hall sensor sample,
// the needle position and the travel direction. For every accepted input word
// the block returns exactly one result word on the m_axis channel, holding the
// detection flag, the kind and position of the last classified carriage and
// whether a hunt is still open after this word.
// The thresholds are set through the write port (index 0 low, index 1 high)
// while no word is in flight; a write takes effect at the next clock edge.
// A word is held in an input register, the hunt state is updated by one level
// of compare and select logic, and the result is captured in an output register.
// One word per cycle is sustained while the receiver does not stall, because
// the state update is combinational and feeds the state registers directly.
// When the receiver stalls, the result stays in the output register and one
// more word is held in the input register before s_axis_tready drops.
// Reset clears the hunt state, the last carriage to none at position zero, and
// the thresholds to 0 and 1023.
module hall_pole_carriage_detector_unit import hpcd_pkg::*; #(
  parameter int unsigned NeedleWindow = NEEDLE_WINDOW_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // [9:0] sample, [17:10] needle_pos, [19:18] travel_dir, [23:20] zero
  input  logic [23:0]        s_axis_tdata,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // [0] detected, [2:1] carriage_kind, [10:3] carriage_pos, [11] hunting, [15:12] zero
  output logic [15:0]        m_axis_tdata,
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_index_i,
  input  logic [SampleW-1:0] cfg_data_i
);

  logic               in_valid_q;
  item_t              in_item_q;
  logic               out_valid_q;
  result_t            out_res_q;
  result_t            res;
  logic               advance;
  logic [SampleW-1:0] low_thr_q, high_thr_q;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_thr_q  <= LOW_THR_RST;
      high_thr_q <= HIGH_THR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_LOW_THR:  low_thr_q  <= cfg_data_i;
        CFG_HIGH_THR: high_thr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item_q <= item_t'(s_axis_tdata[19:0]);
    end
  end

  hpcd_core #(
    .NeedleWindow(NeedleWindow)
  ) u_core (
    .clk_i,
    .rst_ni,
    .step_i     (advance),
    .item_i     (in_item_q),
    .low_thr_i  (low_thr_q),
    .high_thr_i (high_thr_q),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_res_q};

endmodule

// ===== rtl/hpcd_core.sv =====
// Hunt state and combinational update logic of the carriage detector.
`timescale 1ns / 1ps

module hpcd_core import hpcd_pkg::*; #(
  parameter int unsigned NeedleWindow = NEEDLE_WINDOW_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  item_t              item_i,
  input  logic [SampleW-1:0] low_thr_i,
  input  logic [SampleW-1:0] high_thr_i,
  output result_t            res_o
);

  localparam logic [7:0] WinLoad = 8'(NeedleWindow);

  logic               hunt_active_q, hunt_active_d;
  logic [DirW-1:0]    hunt_dir_q, hunt_dir_d;
  logic [7:0]         needles_left_q, needles_left_d;
  logic [SampleW-1:0] min_value_q, min_value_d;
  logic [PosW-1:0]    min_pos_q, min_pos_d;
  logic               min_valid_q, min_valid_d;
  logic [SampleW-1:0] max_value_q, max_value_d;
  logic [PosW-1:0]    max_pos_q, max_pos_d;
  logic               max_valid_q, max_valid_d;
  logic               max_opened_q, max_opened_d;
  kind_e              last_kind_q, last_kind_d;
  logic [PosW-1:0]    last_pos_q, last_pos_d;

  logic               below, above, det;
  logic [PosW:0]      pos_sum;
  logic [7:0]         cnt;

  assign below = item_i.sample < low_thr_i;
  assign above = item_i.sample > high_thr_i;

  always_comb begin
    hunt_active_d  = hunt_active_q;
    hunt_dir_d     = hunt_dir_q;
    needles_left_d = needles_left_q;
    min_value_d    = min_value_q;
    min_pos_d      = min_pos_q;
    min_valid_d    = min_valid_q;
    max_value_d    = max_value_q;
    max_pos_d      = max_pos_q;
    max_valid_d    = max_valid_q;
    max_opened_d   = max_opened_q;
    last_kind_d    = last_kind_q;
    last_pos_d     = last_pos_q;
    det            = 1'b0;
    pos_sum        = '0;
    cnt            = '0;

    if (!hunt_active_q) begin
      hunt_dir_d     = item_i.travel_dir;
      needles_left_d = WinLoad;
      if (below) begin
        hunt_active_d = 1'b1;
        min_value_d   = item_i.sample;
        min_pos_d     = item_i.needle_pos;
        min_valid_d   = 1'b1;
      end else if (above) begin
        hunt_active_d = 1'b1;
        max_value_d   = item_i.sample;
        max_pos_d     = item_i.needle_pos;
        max_valid_d   = 1'b1;
        max_opened_d  = 1'b1;
      end
    end else if (hunt_dir_q != item_i.travel_dir) begin
      hunt_active_d = 1'b0;
      min_valid_d   = 1'b0;
      max_valid_d   = 1'b0;
      max_opened_d  = 1'b0;
      min_value_d   = '0;
      min_pos_d     = '0;
      max_value_d   = '0;
      max_pos_d     = '0;
    end else begin
      cnt = needles_left_q;
      if (below && (!min_valid_q || item_i.sample < min_value_q)) begin
        min_value_d = item_i.sample;
        min_pos_d   = item_i.needle_pos;
        min_valid_d = 1'b1;
        if (!max_valid_q) begin
          cnt = WinLoad;
        end
      end
      if (above && (!max_valid_q || item_i.sample > max_value_q)) begin
        max_value_d = item_i.sample;
        max_pos_d   = item_i.needle_pos;
        max_valid_d = 1'b1;
        if (!min_valid_d) begin
          cnt = WinLoad;
        end
      end
      cnt            = cnt - 8'd1;
      needles_left_d = cnt;
      if (cnt == 8'd0) begin
        pos_sum = {1'b0, min_pos_d} + {1'b0, max_pos_d};
        if (!min_valid_d) begin
          det         = 1'b1;
          last_kind_d = KIND_K;
          last_pos_d  = max_pos_d;
        end else if (!max_valid_d) begin
          det         = 1'b1;
          last_kind_d = KIND_L;
          last_pos_d  = min_pos_d;
        end else if (max_opened_q) begin
          det         = 1'b1;
          last_kind_d = KIND_G;
          last_pos_d  = pos_sum[PosW:1];
        end
        hunt_active_d = 1'b0;
        min_valid_d   = 1'b0;
        max_valid_d   = 1'b0;
        max_opened_d  = 1'b0;
        min_value_d   = '0;
        min_pos_d     = '0;
        max_value_d   = '0;
        max_pos_d     = '0;
      end
    end
  end

  always_comb begin
    res_o.detected      = det;
    res_o.carriage_kind = last_kind_d;
    res_o.carriage_pos  = last_pos_d;
    res_o.hunting       = hunt_active_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hunt_active_q  <= 1'b0;
      hunt_dir_q     <= '0;
      needles_left_q <= '0;
      min_value_q    <= '0;
      min_pos_q      <= '0;
      min_valid_q    <= 1'b0;
      max_value_q    <= '0;
      max_pos_q      <= '0;
      max_valid_q    <= 1'b0;
      max_opened_q   <= 1'b0;
      last_kind_q    <= KIND_NONE;
      last_pos_q     <= '0;
    end else if (step_i) begin
      hunt_active_q  <= hunt_active_d;
      hunt_dir_q     <= hunt_dir_d;
      needles_left_q <= needles_left_d;
      min_value_q    <= min_value_d;
      min_pos_q      <= min_pos_d;
      min_valid_q    <= min_valid_d;
      max_value_q    <= max_value_d;
      max_pos_q      <= max_pos_d;
      max_valid_q    <= max_valid_d;
      max_opened_q   <= max_opened_d;
      last_kind_q    <= last_kind_d;
      last_pos_q     <= last_pos_d;
    end
  end

  a_idle_no_pole: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !hunt_active_q |-> !min_valid_q && !max_valid_q)
    else $error("pole marked valid outside a hunt");

  a_hunt_has_pole: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hunt_active_q |-> min_valid_q || max_valid_q)
    else $error("hunt open without any pole");

  a_opened_by_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    max_opened_q |-> max_valid_q)
    else $error("max-opened flag without a valid maximum");

  a_detect_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && det |=> !hunt_active_q && last_kind_q != KIND_NONE)
    else $error("detection did not close the hunt");

endmodule

// ===== dv/hall_pole_carriage_detector_unit_tb.sv =====
// Self-checking testbench for the hall sensor carriage detector with stream ports.
`timescale 1ns / 1ps

module hall_pole_carriage_detector_unit_tb;
  import hpcd_pkg::*;

  localparam int unsigned WINDOW     = NEEDLE_WINDOW_DEF;
  localparam int unsigned HOLD_LEN   = 60;
  localparam int unsigned IDLE_LIMIT = 3000;

  typedef struct {
    logic               active;
    logic [DirW-1:0]    dir;
    logic [7:0]         left;
    logic [SampleW-1:0] min_v;
    logic [PosW-1:0]    min_p;
    logic               min_ok;
    logic [SampleW-1:0] max_v;
    logic [PosW-1:0]    max_p;
    logic               max_ok;
    logic               max_first;
    kind_e              kind;
    logic [PosW-1:0]    pos;
  } hunt_state_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [23:0]        s_axis_tdata = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [15:0]        m_axis_tdata;
  logic               cfg_we_i = 1'b0;
  logic [0:0]         cfg_index_i = '0;
  logic [SampleW-1:0] cfg_data_i = '0;

  hunt_state_t        hunt;
  logic [SampleW-1:0] thr_low;
  logic [SampleW-1:0] thr_high;
  result_t            expected_q[$];

  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned hold_req_cnt = 0;
  int unsigned hold_seen_cnt = 0;
  int unsigned hold_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned n_sent = 0;
  int unsigned n_checked = 0;
  int unsigned n_settings = 0;
  int unsigned n_kind[4] = '{0, 0, 0, 0};
  int unsigned errors = 0;

  hall_pole_carriage_detector_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  task automatic close_hunt();
    hunt.active    = 1'b0;
    hunt.min_v     = '0;
    hunt.min_p     = '0;
    hunt.min_ok    = 1'b0;
    hunt.max_v     = '0;
    hunt.max_p     = '0;
    hunt.max_ok    = 1'b0;
    hunt.max_first = 1'b0;
  endtask

  task automatic reset_hunt();
    thr_low   = LOW_THR_RST;
    thr_high  = HIGH_THR_RST;
    hunt.dir  = '0;
    hunt.left = '0;
    hunt.kind = KIND_NONE;
    hunt.pos  = '0;
    close_hunt();
  endtask

  task automatic classify_carriage(output logic found);
    found = 1'b1;
    if (!hunt.min_ok) begin
      hunt.kind = KIND_K;
      hunt.pos  = hunt.max_p;
    end else if (!hunt.max_ok) begin
      hunt.kind = KIND_L;
      hunt.pos  = hunt.min_p;
    end else if (hunt.max_first) begin
      hunt.kind = KIND_G;
      hunt.pos  = PosW'(({1'b0, hunt.min_p} + {1'b0, hunt.max_p}) >> 1);
    end else begin
      found = 1'b0;
    end
  endtask

  task automatic track_hunt(input item_t it, output result_t res);
    logic below;
    logic above;
    logic det;
    below = it.sample < thr_low;
    above = it.sample > thr_high;
    det   = 1'b0;
    if (!hunt.active) begin
      hunt.dir  = it.travel_dir;
      hunt.left = 8'(WINDOW);
      if (below) begin
        hunt.active = 1'b1;
        hunt.min_v  = it.sample;
        hunt.min_p  = it.needle_pos;
        hunt.min_ok = 1'b1;
      end else if (above) begin
        hunt.active    = 1'b1;
        hunt.max_v     = it.sample;
        hunt.max_p     = it.needle_pos;
        hunt.max_ok    = 1'b1;
        hunt.max_first = 1'b1;
      end
    end else if (hunt.dir != it.travel_dir) begin
      close_hunt();
    end else begin
      if (below && (!hunt.min_ok || it.sample < hunt.min_v)) begin
        hunt.min_v  = it.sample;
        hunt.min_p  = it.needle_pos;
        hunt.min_ok = 1'b1;
        if (!hunt.max_ok) hunt.left = 8'(WINDOW);
      end
      if (above && (!hunt.max_ok || it.sample > hunt.max_v)) begin
        hunt.max_v  = it.sample;
        hunt.max_p  = it.needle_pos;
        hunt.max_ok = 1'b1;
        if (!hunt.min_ok) hunt.left = 8'(WINDOW);
      end
      hunt.left = hunt.left - 8'd1;
      if (hunt.left == 8'd0) begin
        classify_carriage(det);
        close_hunt();
      end
    end
    res.detected      = det;
    res.carriage_kind = hunt.kind;
    res.carriage_pos  = hunt.pos;
    res.hunting       = hunt.active;
  endtask

  task automatic send_word(input item_t it);
    int unsigned gap;
    result_t     res;
    gap = 0;
    while ($urandom_range(99) < src_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, it};
    do @(posedge clk_i); while (!s_axis_tready);
    track_hunt(it, res);
    expected_q.push_back(res);
    n_sent++;
  endtask

  task automatic send_fields(input int unsigned s, input int unsigned p, input int unsigned d);
    item_t it;
    it.sample     = SampleW'(s);
    it.needle_pos = PosW'(p);
    it.travel_dir = DirW'(d);
    send_word(it);
  endtask

  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [SampleW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_LOW_THR) thr_low = val;
    else thr_high = val;
  endtask

  task automatic set_thresholds(input int unsigned lo, input int unsigned hi);
    wait_results_drained();
    write_reg(CFG_LOW_THR, SampleW'(lo));
    write_reg(CFG_HIGH_THR, SampleW'(hi));
    n_settings++;
  endtask

  function automatic logic [SampleW-1:0] pick_below();
    if (thr_low == 0) return SampleW'($urandom);
    return SampleW'($urandom_range(thr_low - 1, 0));
  endfunction

  function automatic logic [SampleW-1:0] pick_above();
    if (thr_high == 10'd1023) return SampleW'($urandom);
    return SampleW'($urandom_range(1023, thr_high + 1));
  endfunction

  function automatic logic [SampleW-1:0] pick_between();
    if (thr_low > thr_high) return SampleW'($urandom);
    return SampleW'($urandom_range(thr_high, thr_low));
  endfunction

  // Mostly well-formed passes: one direction, an opening pole, then a few needles.
  task automatic send_hunt_runs(input int unsigned count);
    int unsigned sent;
    int unsigned run_len;
    int unsigned roll;
    logic [DirW-1:0] dir;
    logic [PosW-1:0] pos;
    item_t it;
    sent = 0;
    pos  = PosW'($urandom);
    while (sent < count) begin
      if ($urandom_range(99) < 20) begin
        it.sample     = SampleW'($urandom);
        it.needle_pos = PosW'($urandom);
        it.travel_dir = DirW'($urandom);
        send_word(it);
        sent++;
      end else begin
        dir     = ($urandom_range(9) == 0) ? DirW'($urandom) : DirW'($urandom_range(2, 1));
        run_len = $urandom_range(6, 2);
        for (int k = 0; k < run_len && sent < count; k++) begin
          roll = $urandom_range(99);
          if (k == 0) it.sample = (roll < 50) ? pick_below() : pick_above();
          else if (roll < 25) it.sample = pick_below();
          else if (roll < 50) it.sample = pick_above();
          else it.sample = pick_between();
          it.needle_pos = pos;
          it.travel_dir = (k > 0 && $urandom_range(14) == 0) ? dir + 2'd1 : dir;
          pos = ($urandom_range(9) == 0) ? PosW'($urandom) : pos + 8'd1;
          send_word(it);
          sent++;
        end
      end
    end
  endtask

  task automatic test_reset_defaults();
    send_fields(0, 0, 0);
    send_fields(1023, 255, 3);
    send_fields(682, 170, 2);
    send_fields(341, 85, 1);
  endtask

  task automatic test_single_poles();
    set_thresholds(300, 700);
    // A larger maximum restarts the window before the K carriage is reported.
    send_fields(800, 10, 1);
    send_fields(500, 11, 1);
    send_fields(900, 12, 1);
    send_fields(500, 13, 1);
    send_fields(500, 14, 1);
    send_fields(0, 255, 2);
    send_fields(500, 0, 2);
    send_fields(500, 1, 2);
    send_fields(500, 2, 2);
  endtask

  task automatic test_mixed_poles();
    // Maximum first gives G at the mid position; minimum first reports nothing.
    send_fields(1023, 250, 1);
    send_fields(5, 255, 1);
    send_fields(500, 3, 1);
    send_fields(500, 4, 1);
    send_fields(100, 20, 2);
    send_fields(1000, 21, 2);
    send_fields(500, 22, 2);
    send_fields(500, 23, 2);
  endtask

  task automatic test_direction_change();
    send_fields(900, 30, 1);
    send_fields(900, 31, 2);
    send_fields(500, 32, 2);
  endtask

  task automatic test_inverted_thresholds();
    // With low above high, a sample between the two thresholds is both a minimum and a maximum.
    set_thresholds(1023, 0);
    send_fields(500, 40, 3);
    send_fields(1023, 41, 3);
    send_fields(0, 42, 3);
    send_fields(600, 43, 3);
  endtask

  task automatic test_backpressure();
    set_thresholds(300, 700);
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_req_cnt++;
    send_hunt_runs(30);
  endtask

  task automatic test_drain_pause();
    src_idle_pct   = 0;
    sink_stall_pct = 62;
    send_hunt_runs(10);
    wait_results_drained();
    send_hunt_runs(10);
  endtask

  task automatic run_random_phase(input int unsigned lo, input int unsigned hi,
                                  input int unsigned src, input int unsigned sink,
                                  input int unsigned count);
    set_thresholds(lo, hi);
    src_idle_pct   = src;
    sink_stall_pct = sink;
    send_hunt_runs(count);
  endtask

  task automatic test_random_mix();
    run_random_phase(300, 700, 0, 0, 50);
    run_random_phase(1023, 0, 62, 0, 60);
    run_random_phase(150, 850, 0, 62, 50);
    run_random_phase(0, 600, 31, 31, 60);
    run_random_phase(400, 1023, 0, 0, 60);
    run_random_phase(512, 511, 31, 31, 60);
    run_random_phase($urandom_range(450, 100), $urandom_range(950, 550), 0, 62, 60);
    run_random_phase(0, 1023, 31, 31, 20);
  endtask

  always @(posedge clk_i) begin
    if (hold_req_cnt != hold_seen_cnt) begin
      hold_seen_cnt <= hold_req_cnt;
      hold_left     <= HOLD_LEN;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i) begin
    result_t exp_r;
    result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata[11:0]);
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, expected none, actual 0x%h", $time,
                 m_axis_tdata);
      end else begin
        exp_r = expected_q.pop_front();
        check_field("detected", exp_r.detected, got.detected);
        check_field("carriage_kind", exp_r.carriage_kind, got.carriage_kind);
        check_field("carriage_pos", exp_r.carriage_pos, got.carriage_pos);
        check_field("hunting", exp_r.hunting, got.hunting);
        check_field("padding", 0, m_axis_tdata[15:12]);
        if (exp_r.detected) n_kind[exp_r.carriage_kind]++;
        n_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
      $display("hall_pole_carriage_detector_unit_tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    reset_hunt();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_single_poles();
    test_mixed_poles();
    test_direction_change();
    test_inverted_thresholds();
    test_backpressure();
    test_drain_pause();
    test_random_mix();
    wait_results_drained();
    repeat (5) @(posedge clk_i);
    $display("Sent %0d words across %0d threshold settings and four idle mixes.",
             n_sent, n_settings);
    $display("Checked %0d results with %0d K, %0d L and %0d G carriages.",
             n_checked, n_kind[KIND_K], n_kind[KIND_L], n_kind[KIND_G]);
    if (errors == 0) begin
      $display("hall_pole_carriage_detector_unit_tb passed");
    end else begin
      $display("hall_pole_carriage_detector_unit_tb failed");
    end
    $finish;
  end

endmodule
